// ===== hw/rtl/qvr_pkg.sv =====
// Shared types and constants for the quaternion vector rotator.
// Used by qvr_numer, qvr_div and quaternion_vector_rotate; no dependencies.
package qvr_pkg;

  localparam int unsigned CompW  = 16;  // input component width
  localparam int unsigned RotW   = 17;  // rotated component width
  localparam int unsigned NumW   = 52;  // signed numerator width
  localparam int unsigned DenW   = 33;  // unsigned norm (sum of squares) width
  localparam int unsigned QuotW  = 17;  // quotient bits produced by the divider
  localparam int unsigned RemW   = 53;  // partial remainder width
  localparam int unsigned NumLat = 4;   // register stages in qvr_numer
  localparam int unsigned DivLat = QuotW + 2;  // prep, one stage per bit, result

  localparam logic signed [RotW-1:0] RotMax = 17'sd65535;
  localparam logic signed [RotW-1:0] RotMin = -17'sd65536;

  typedef struct packed {
    logic signed [NumW-1:0] nx;
    logic signed [NumW-1:0] ny;
    logic signed [NumW-1:0] nz;
    logic [DenW-1:0]        s;
    logic                   zero;
  } qvr_num_t;

endpackage

// ===== hw/rtl/qvr_numer.sv =====
// Four-stage pipeline forming the exact numerators and the norm s.
// Depends on qvr_pkg.
module qvr_numer import qvr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [CompW-1:0] qw_i,
  input  logic signed [CompW-1:0] qx_i,
  input  logic signed [CompW-1:0] qy_i,
  input  logic signed [CompW-1:0] qz_i,
  input  logic signed [CompW-1:0] vx_i,
  input  logic signed [CompW-1:0] vy_i,
  input  logic signed [CompW-1:0] vz_i,
  output qvr_num_t                num_o
);

  // Stage 1: all 16x16 products.
  logic signed [31:0] ww_q, xx_q, yy_q, zz_q;
  logic signed [31:0] xvx_q, yvy_q, zvz_q;
  logic signed [31:0] yvz_q, zvy_q, zvx_q, xvz_q, xvy_q, yvx_q;
  logic signed [CompW-1:0] w1_q, x1_q, y1_q, z1_q, vx1_q, vy1_q, vz1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ww_q  <= qw_i * qw_i;
      xx_q  <= qx_i * qx_i;
      yy_q  <= qy_i * qy_i;
      zz_q  <= qz_i * qz_i;
      xvx_q <= qx_i * vx_i;
      yvy_q <= qy_i * vy_i;
      zvz_q <= qz_i * vz_i;
      yvz_q <= qy_i * vz_i;
      zvy_q <= qz_i * vy_i;
      zvx_q <= qz_i * vx_i;
      xvz_q <= qx_i * vz_i;
      xvy_q <= qx_i * vy_i;
      yvx_q <= qy_i * vx_i;
      w1_q  <= qw_i;
      x1_q  <= qx_i;
      y1_q  <= qy_i;
      z1_q  <= qz_i;
      vx1_q <= vx_i;
      vy1_q <= vy_i;
      vz1_q <= vz_i;
    end
  end

  // Stage 2: norm, scalar factors and cross product.
  logic signed [34:0] s_d, p_d;
  logic signed [33:0] dot_d;
  logic signed [34:0] p_q;
  logic signed [33:0] d2_q;
  logic signed [32:0] cx_q, cy_q, cz_q;
  logic signed [16:0] w2_q;
  logic [DenW-1:0]    s2_q;
  logic               zero2_q;
  logic signed [CompW-1:0] x2_q, y2_q, z2_q, vx2_q, vy2_q, vz2_q;

  always_comb begin
    s_d = {{3{ww_q[31]}}, ww_q} + {{3{xx_q[31]}}, xx_q}
        + {{3{yy_q[31]}}, yy_q} + {{3{zz_q[31]}}, zz_q};
    p_d = {{2{ww_q[31]}}, ww_q, 1'b0} - s_d;
    dot_d = {{2{xvx_q[31]}}, xvx_q} + {{2{yvy_q[31]}}, yvy_q}
          + {{2{zvz_q[31]}}, zvz_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q     <= p_d;
      d2_q    <= {dot_d[32:0], 1'b0};
      cx_q    <= {yvz_q[31], yvz_q} - {zvy_q[31], zvy_q};
      cy_q    <= {zvx_q[31], zvx_q} - {xvz_q[31], xvz_q};
      cz_q    <= {xvy_q[31], xvy_q} - {yvx_q[31], yvx_q};
      w2_q    <= {w1_q, 1'b0};
      s2_q    <= s_d[DenW-1:0];
      zero2_q <= (s_d == 35'sd0);
      x2_q    <= x1_q;
      y2_q    <= y1_q;
      z2_q    <= z1_q;
      vx2_q   <= vx1_q;
      vy2_q   <= vy1_q;
      vz2_q   <= vz1_q;
    end
  end

  // Stage 3: the nine products of the rotation formula.
  logic signed [50:0] pvx_q, pvy_q, pvz_q;
  logic signed [49:0] dux_q, duy_q, duz_q;
  logic signed [49:0] wcx_q, wcy_q, wcz_q;
  logic [DenW-1:0]    s3_q;
  logic               zero3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pvx_q   <= p_q * vx2_q;
      pvy_q   <= p_q * vy2_q;
      pvz_q   <= p_q * vz2_q;
      dux_q   <= d2_q * x2_q;
      duy_q   <= d2_q * y2_q;
      duz_q   <= d2_q * z2_q;
      wcx_q   <= w2_q * cx_q;
      wcy_q   <= w2_q * cy_q;
      wcz_q   <= w2_q * cz_q;
      s3_q    <= s2_q;
      zero3_q <= zero2_q;
    end
  end

  // Stage 4: sum into the exact numerators.
  qvr_num_t num_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q.nx   <= {pvx_q[50], pvx_q} + {{2{dux_q[49]}}, dux_q}
                  + {{2{wcx_q[49]}}, wcx_q};
      num_q.ny   <= {pvy_q[50], pvy_q} + {{2{duy_q[49]}}, duy_q}
                  + {{2{wcy_q[49]}}, wcy_q};
      num_q.nz   <= {pvz_q[50], pvz_q} + {{2{duz_q[49]}}, duz_q}
                  + {{2{wcz_q[49]}}, wcz_q};
      num_q.s    <= s3_q;
      num_q.zero <= zero3_q;
    end
  end

  assign num_o = num_q;

endmodule

// ===== hw/rtl/qvr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, rounding to nearest
// with ties away from zero and a final 17-bit clamp. Depends on qvr_pkg.
module qvr_div import qvr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic [DenW-1:0]        den_i,
  output logic signed [RotW-1:0] rot_o
);

  // Rounding is folded in as floor((2|n| + s) / 2s).
  logic [RemW-1:0]  rem_q  [QuotW+1];
  logic [DenW:0]    den_q  [QuotW+1];
  logic [QuotW-1:0] quo_q  [QuotW+1];
  logic             neg_q  [QuotW+1];
  logic [NumW-1:0]  mag_d;

  assign mag_d = num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {mag_d, 1'b0} + {{(RemW-DenW){1'b0}}, den_i};
      den_q[0] <= {den_i, 1'b0};
      quo_q[0] <= '0;
      neg_q[0] <= num_i[NumW-1];
    end
  end

  for (genvar i = 1; i <= QuotW; i++) begin : g_bit
    localparam int unsigned Sh = QuotW - i;
    logic [RemW-1:0] trial;
    logic            fits;

    assign trial = {{(RemW-DenW-1){1'b0}}, den_q[i-1]} << Sh;
    assign fits  = (rem_q[i-1] >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= fits ? rem_q[i-1] - trial : rem_q[i-1];
        den_q[i] <= den_q[i-1];
        quo_q[i] <= {quo_q[i-1][QuotW-2:0], fits};
        neg_q[i] <= neg_q[i-1];
      end
    end
  end

  logic signed [RotW:0]   sgn_d;
  logic signed [RotW-1:0] rot_q;

  always_comb begin
    sgn_d = neg_q[QuotW] ? -$signed({1'b0, quo_q[QuotW]})
                         : $signed({1'b0, quo_q[QuotW]});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (sgn_d > $signed({RotMax[RotW-1], RotMax})) begin
        rot_q <= RotMax;
      end else if (sgn_d < $signed({RotMin[RotW-1], RotMin})) begin
        rot_q <= RotMin;
      end else begin
        rot_q <= sgn_d[RotW-1:0];
      end
    end
  end

  assign rot_o = rot_q;

endmodule

// ===== hw/rtl/quaternion_vector_rotate.sv =====
// Rotates a 3-vector by a quaternion of any scale, with exact integer arithmetic
// and one rounded division per component. Each transfer in gives one transfer
// out, and a new item is taken every cycle while the output is not stalled:
// four stages build the numerators and the norm, and three 19-stage
// bit-per-stage dividers finish the result. The whole pipeline holds when the
// output is stalled. An all-zero quaternion sets tuser and returns a zero vector.
module quaternion_vector_rotate import qvr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z (16 bits each)
  input  logic [111:0]  s_axis_tdata_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // rot_x, rot_y, rot_z (17 bits each), zero padding
  output logic [55:0]   m_axis_tdata_o,
  // zero_quat
  output logic          m_axis_tuser_o
);

  localparam int unsigned TotLat = NumLat + DivLat;

  logic                  en;
  logic [TotLat-1:0]     vld_q;
  logic [DivLat-1:0]     zero_q;
  qvr_num_t              num;
  logic signed [RotW-1:0] rx, ry, rz;

  assign en = ~vld_q[TotLat-1] | m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TotLat-2:0], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_q <= {zero_q[DivLat-2:0], num.zero};
    end
  end

  qvr_numer u_numer (
    .clk_i (clk_i),
    .en_i  (en),
    .qw_i  (s_axis_tdata_i[15:0]),
    .qx_i  (s_axis_tdata_i[31:16]),
    .qy_i  (s_axis_tdata_i[47:32]),
    .qz_i  (s_axis_tdata_i[63:48]),
    .vx_i  (s_axis_tdata_i[79:64]),
    .vy_i  (s_axis_tdata_i[95:80]),
    .vz_i  (s_axis_tdata_i[111:96]),
    .num_o (num)
  );

  qvr_div u_div_x (.clk_i(clk_i), .en_i(en), .num_i(num.nx), .den_i(num.s), .rot_o(rx));
  qvr_div u_div_y (.clk_i(clk_i), .en_i(en), .num_i(num.ny), .den_i(num.s), .rot_o(ry));
  qvr_div u_div_z (.clk_i(clk_i), .en_i(en), .num_i(num.nz), .den_i(num.s), .rot_o(rz));

  logic zq;
  assign zq = zero_q[DivLat-1];

  assign m_axis_tvalid_o = vld_q[TotLat-1];
  assign m_axis_tuser_o  = zq;
  assign m_axis_tdata_o  = {5'b0,
                            zq ? {RotW{1'b0}} : rz,
                            zq ? {RotW{1'b0}} : ry,
                            zq ? {RotW{1'b0}} : rx};

`ifndef SYNTHESIS
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow output stall");

  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == 56'd0))
    else $error("zero quaternion gave a nonzero vector");

  a_hold_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |=> $stable(vld_q))
    else $error("pipeline moved while stalled");
`endif

endmodule

// ===== tb/sv/quaternion_vector_rotate_test.sv =====
// Self-checking testbench for quaternion_vector_rotate: directed table, then random items,
// each result checked against its table value or the in-bench exact rotation predictor.
// Depends on qvr_pkg and the quaternion_vector_rotate RTL.
module quaternion_vector_rotate_test;
  timeunit 1ns;
  timeprecision 1ps;
  import qvr_pkg::*;

  typedef struct packed {
    logic signed [15:0] vz, vy, vx, qz, qy, qx, qw;
  } rot_req_t;

  typedef struct packed {
    logic [4:0]         pad;
    logic signed [16:0] rz, ry, rx;
  } rot_data_t;

  typedef struct packed {
    rot_data_t d;
    logic      zero;
  } rot_res_t;

  typedef struct {
    rot_req_t req;
    logic     has_exp;
    rot_res_t exp;
  } stim_row_t;

  localparam int unsigned NumRandom = 700;
  localparam longint CycleLimit = 400000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid_i = 1'b0;
  logic          s_axis_tready_o;
  logic [111:0]  s_axis_tdata_i = '0;
  logic          m_axis_tvalid_o;
  logic          m_axis_tready_i = 1'b0;
  logic [55:0]   m_axis_tdata_o;
  logic          m_axis_tuser_o;

  rot_res_t expected_rot_q[$];
  int       mismatches = 0;
  bit       calm = 1'b0;      // no idling in the last part of the run
  bit       stim_done = 1'b0;
  longint   cycles = 0;

  quaternion_vector_rotate uut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Round-to-nearest division, ties away from zero, then 17-bit saturation.
  function automatic logic signed [16:0] round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    if (num < 0) q = -q;
    if (q > 65535) q = 65535;
    if (q < -65536) q = -65536;
    return q[16:0];
  endfunction

  function automatic rot_res_t rotate_vector(rot_req_t r);
    rot_res_t res;
    longint w, ux, uy, uz, vx, vy, vz, s, p, d2, cx, cy, cz;
    w = r.qw; ux = r.qx; uy = r.qy; uz = r.qz;
    vx = r.vx; vy = r.vy; vz = r.vz;
    s = w * w + ux * ux + uy * uy + uz * uz;
    res.d = '0;
    res.zero = (s == 0);
    if (s != 0) begin
      p = 2 * w * w - s;
      d2 = 2 * (ux * vx + uy * vy + uz * vz);
      cx = uy * vz - uz * vy;
      cy = uz * vx - ux * vz;
      cz = ux * vy - uy * vx;
      res.d.rx = round_div(p * vx + d2 * ux + 2 * w * cx, s);
      res.d.ry = round_div(p * vy + d2 * uy + 2 * w * cy, s);
      res.d.rz = round_div(p * vz + d2 * uz + 2 * w * cz, s);
    end
    return res;
  endfunction

  function automatic rot_req_t mk_req(int qw, int qx, int qy, int qz, int vx, int vy, int vz);
    rot_req_t r;
    r.qw = 16'(qw); r.qx = 16'(qx); r.qy = 16'(qy); r.qz = 16'(qz);
    r.vx = 16'(vx); r.vy = 16'(vy); r.vz = 16'(vz);
    return r;
  endfunction

  function automatic rot_res_t mk_res(int rx, int ry, int rz, logic zero);
    rot_res_t r;
    r.d = '0;
    r.d.rx = 17'(rx); r.d.ry = 17'(ry); r.d.rz = 17'(rz);
    r.zero = zero;
    return r;
  endfunction

  function automatic rot_req_t random_req();
    rot_req_t r;
    int pick;
    r = 112'({$urandom, $urandom, $urandom, $urandom});
    pick = $urandom_range(0, 9);
    // Small quaternions make rounding ties and coarse rotations common.
    if (pick < 3) begin
      r.qw = 16'($urandom_range(0, 6) - 3);
      r.qx = 16'($urandom_range(0, 6) - 3);
      r.qy = 16'($urandom_range(0, 6) - 3);
      r.qz = 16'($urandom_range(0, 6) - 3);
    end else if (pick == 3) begin
      r.qw = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      r.qx = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end else if (pick == 4) begin
      r.qx = '0; r.qy = '0; r.qz = '0;
      if ($urandom_range(0, 1)) r.qw = '0;
    end
    return r;
  endfunction

  // Moves one request across the input handshake. Called at a falling edge;
  // ready is read once the falling-edge updates have settled.
  task automatic send_req(rot_req_t r);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= r;
    #1;
    while (!s_axis_tready_o) begin
      @(negedge clk_i);
      #1;
    end
    @(posedge clk_i);
    expected_rot_q.push_back(rotate_vector(r));
    @(negedge clk_i);
  endtask

  stim_row_t rows[$];

  initial begin
    stim_row_t row;
    rot_res_t pred;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    row.has_exp = 1'b1;
    // Zero quaternion gives the flag and a zero vector.
    row.req = mk_req(0, 0, 0, 0, 100, -200, 300); row.exp = mk_res(0, 0, 0, 1);
    rows.push_back(row);
    row.req = mk_req(0, 0, 0, 0, -32768, 32767, -1); row.exp = mk_res(0, 0, 0, 1);
    rows.push_back(row);
    // Identity rotations at extreme vectors and scales.
    row.req = mk_req(1, 0, 0, 0, -32768, 32767, 0); row.exp = mk_res(-32768, 32767, 0, 0);
    rows.push_back(row);
    row.req = mk_req(-32768, 0, 0, 0, 32767, -32768, -1);
    row.exp = mk_res(32767, -32768, -1, 0);
    rows.push_back(row);
    // Half turn about x negates y and z.
    row.req = mk_req(0, 32767, 0, 0, 5, -32768, 32767); row.exp = mk_res(5, 32768, -32767, 0);
    rows.push_back(row);
    // Quarter turn about z: (x, y) -> (-y, x).
    row.req = mk_req(1, 0, 0, 1, 10, 20, 30); row.exp = mk_res(-20, 10, 30, 0);
    rows.push_back(row);
    row.has_exp = 1'b0;
    row.req = mk_req(32767, 32767, 32767, 32767, 32767, 32767, 32767); rows.push_back(row);
    row.req = mk_req(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
    rows.push_back(row);
    row.req = mk_req(-32768, 32767, -32768, 32767, 32767, -32768, 32767); rows.push_back(row);
    row.req = mk_req(0, 1, 1, 1, -32768, 32767, -32768); rows.push_back(row);
    // Rounding cases with small and patterned quaternions.
    row.req = mk_req(1, 1, 0, 0, 1, 1, 0); rows.push_back(row);
    row.req = mk_req(1, 1, 1, 0, 1, -1, 1); rows.push_back(row);
    row.req = mk_req(2, 1, 1, 1, -3, 3, -3); rows.push_back(row);
    row.req = mk_req(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'haaaa);
    rows.push_back(row);

    foreach (rows[i]) begin
      if (rows[i].has_exp) begin
        pred = rotate_vector(rows[i].req);
        if (pred != rows[i].exp) begin
          $display("%0t: table row %0d expected %h actual predictor %h", $realtime, i,
                   rows[i].exp, pred);
          mismatches++;
        end
      end
      send_req(rows[i].req);
      if (rows[i].has_exp) begin
        expected_rot_q.pop_back();
        expected_rot_q.push_back(rows[i].exp);
      end
    end
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom - 100) calm = 1'b1;
      send_req(random_req());
    end
    s_axis_tvalid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stall bursts, plus one long hold-off to back up the pipeline.
  initial begin
    int hold;
    @(posedge rst_ni);
    repeat (20) @(negedge clk_i);
    m_axis_tready_i <= 1'b0;
    for (hold = 0; hold < 80; hold++) @(negedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(negedge clk_i);
    end
  end

  // Output values are stable from just after the falling edge up to the rising
  // edge, so they are captured there and checked at the rising edge.
  initial begin
    rot_res_t got;
    rot_res_t exp;
    logic     take;
    forever begin
      @(negedge clk_i);
      #1;
      take = rst_ni && m_axis_tvalid_o && m_axis_tready_i;
      got.d = m_axis_tdata_o;
      got.zero = m_axis_tuser_o;
      @(posedge clk_i);
      if (take) begin
        if (expected_rot_q.size() == 0) begin
          $display("%0t: unexpected transfer out, actual %h/%b", $realtime, got.d, got.zero);
          mismatches++;
        end else begin
          exp = expected_rot_q.pop_front();
          if (got.d.rx !== exp.d.rx) begin
            $display("%0t: rot_x expected %0d actual %0d", $realtime, exp.d.rx, got.d.rx);
            mismatches++;
          end
          if (got.d.ry !== exp.d.ry) begin
            $display("%0t: rot_y expected %0d actual %0d", $realtime, exp.d.ry, got.d.ry);
            mismatches++;
          end
          if (got.d.rz !== exp.d.rz) begin
            $display("%0t: rot_z expected %0d actual %0d", $realtime, exp.d.rz, got.d.rz);
            mismatches++;
          end
          if (got.d.pad !== exp.d.pad) begin
            $display("%0t: padding expected %h actual %h", $realtime, exp.d.pad, got.d.pad);
            mismatches++;
          end
          if (got.zero !== exp.zero) begin
            $display("%0t: zero_quat expected %b actual %b", $realtime, exp.zero, got.zero);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (expected_rot_q.size() != 0 && cycles < CycleLimit) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && expected_rot_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
hw/rtl/qvr_pkg.sv
hw/rtl/qvr_numer.sv
hw/rtl/qvr_div.sv
hw/rtl/quaternion_vector_rotate.sv
tb/sv/quaternion_vector_rotate_test.sv
